### design/rrm_pkg.sv
// Package for the raw region moment block: word structs, control structs and constants.
// It depends on nothing. Every module of the block imports it.
package rrm_pkg;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LABEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_X      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_Y      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd3;

    // Reset value of the image width register.
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 11'd1024;

    // Width of an effective exponent; it holds every order up to four.
    localparam int ORD_W = 3;

    // Saturation limits: the largest sum and the cap on a single term.
    localparam logic [30:0] SUM_MAX  = 31'h7FFF_FFFF;
    localparam logic [31:0] TERM_CAP = 32'h8000_0000;

    // Input word: one pixel label and the end-of-image mark.
    typedef struct packed {
        logic [7:0] pixel;
        logic       last_pixel;
    } t_in_word;

    // Output word: the moment and its overflow flag.
    typedef struct packed {
        logic [30:0] moment_sum;
        logic        overflow;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_x;
        logic mul_y;
        logic add;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             hit;
        logic             last;
        logic             out_busy;
        logic [ORD_W-1:0] ord_x;
        logic [ORD_W-1:0] ord_y;
    } t_status;

endpackage

### design/rrm_ctrl.sv
// Controller of the raw region moment block: sequences one pixel through its steps.
// It depends on rrm_pkg for the command and status structs.
module rrm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rrm_pkg::t_status i_status,
    output rrm_pkg::t_cmd    o_cmd
);
    import rrm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MULX,
        S_MULY,
        S_ADD
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [ORD_W-1:0] r_cnt;
    logic [ORD_W-1:0] n_cnt;

    // Next state and the commands for this cycle.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = i_status.ord_x;
                    n_state    = S_MULX;
                end
            end
            S_MULX: begin
                // One column factor per cycle; a pixel that misses skips the products.
                if (i_status.hit && (r_cnt != '0)) begin
                    o_cmd.mul_x = 1'b1;
                    n_cnt       = r_cnt - ORD_W'(1);
                end else begin
                    n_cnt   = i_status.ord_y;
                    n_state = S_MULY;
                end
            end
            S_MULY: begin
                if (i_status.hit && (r_cnt != '0)) begin
                    o_cmd.mul_y = 1'b1;
                    n_cnt       = r_cnt - ORD_W'(1);
                end else begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                // The last pixel waits here while the previous result is still untaken.
                if (!(i_status.last && i_status.out_busy)) begin
                    o_cmd.add  = 1'b1;
                    o_cmd.emit = i_status.last;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### design/rrm_dpath.sv
// Datapath of the raw region moment block: registers, position counters, the shared
// multiplier, the saturating accumulator and the output register. It depends on rrm_pkg.
module rrm_dpath #(
    parameter int MAX_DIM   = 1024,
    parameter int MAX_ORDER = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rrm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  rrm_pkg::t_in_word                 i_in_word,
    input  rrm_pkg::t_cmd                     i_cmd,
    output rrm_pkg::t_status                  o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rrm_pkg::t_out_word                o_out_word
);
    import rrm_pkg::*;

    localparam int CDW  = $clog2(MAX_DIM);
    localparam int WW   = (CDW + 1 > CFG_DATA_W) ? CDW + 1 : CFG_DATA_W;
    localparam int PW   = 32 + CDW;

    // Configuration registers.
    logic [7:0]            r_target;
    logic [1:0]            r_order_x;
    logic [1:0]            r_order_y;
    logic [CFG_DATA_W-1:0] r_width;

    // Per-image state and per-pixel working registers.
    logic [CDW-1:0] r_col;
    logic [CDW-1:0] r_row;
    logic [30:0]    r_acc;
    logic           r_ovf;
    logic [31:0]    r_term;
    logic           r_hit;
    logic           r_last;
    t_out_word      r_out;
    logic           r_out_valid;

    logic [WW-1:0]  width_ext;
    logic [WW-1:0]  width_eff;
    logic [WW-1:0]  col_inc;
    logic [CDW-1:0] base;
    logic [PW-1:0]  prod;
    logic [31:0]    term_sel;
    logic [32:0]    sum;
    logic [30:0]    acc_new;
    logic           ovf_new;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_order_x <= '0;
            r_order_y <= '0;
            r_width   <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET_LABEL: r_target  <= i_cfg_data[7:0];
                CFG_ORDER_X:      r_order_x <= i_cfg_data[1:0];
                CFG_ORDER_Y:      r_order_y <= i_cfg_data[1:0];
                CFG_IMAGE_WIDTH:  r_width   <= i_cfg_data;
                default:          r_width   <= r_width;
            endcase
        end
    end

    // Effective exponents, saturated at the largest supported order.
    always_comb begin
        o_status.ord_x = ({1'b0, r_order_x} > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
                                                               : {1'b0, r_order_x};
        o_status.ord_y = ({1'b0, r_order_y} > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
                                                               : {1'b0, r_order_y};
        o_status.hit      = r_hit;
        o_status.last     = r_last;
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

    // Effective width: zero acts as one, and anything above the largest dimension is clamped.
    always_comb begin
        width_ext = WW'(r_width);
        if (width_ext == '0) begin
            width_eff = WW'(1);
        end else if (width_ext > WW'(MAX_DIM)) begin
            width_eff = WW'(MAX_DIM);
        end else begin
            width_eff = width_ext;
        end
        col_inc = WW'(r_col) + WW'(1);
    end

    // One power factor per cycle, saturating at the term cap.
    assign base = i_cmd.mul_x ? r_col : r_row;
    assign prod = PW'(r_term) * PW'(base);

    // Saturating add of the term into the accumulator.
    always_comb begin
        term_sel = r_hit ? r_term : 32'd0;
        sum      = {1'b0, term_sel} + {2'b00, r_acc};
        if (sum > {2'b00, SUM_MAX}) begin
            acc_new = SUM_MAX;
            ovf_new = 1'b1;
        end else begin
            acc_new = sum[30:0];
            ovf_new = r_ovf;
        end
    end

    // Pixel capture and term register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit  <= (i_in_word.pixel == r_target);
            r_last <= i_in_word.last_pixel;
            r_term <= 32'd1;
        end else if (i_cmd.mul_x || i_cmd.mul_y) begin
            r_term <= (prod > PW'(TERM_CAP)) ? TERM_CAP : prod[31:0];
        end
    end

    // Accumulator, flag and raster position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.add) begin
            if (r_last) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_acc <= acc_new;
                r_ovf <= ovf_new;
                if (col_inc >= width_eff) begin
                    r_col <= '0;
                    r_row <= (r_row == CDW'(MAX_DIM - 1)) ? '0 : r_row + CDW'(1);
                end else begin
                    r_col <= r_col + CDW'(1);
                end
            end
        end
    end

    // Output register: holds a result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.moment_sum <= acc_new;
            r_out.overflow   <= ovf_new;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### design/region_raw_moment.sv
// Top level of the raw region moment block: joins the controller and the datapath.
// It depends on rrm_pkg, rrm_ctrl and rrm_dpath.
//
// The block takes a label image one pixel word at a time in raster order and sums
// column^p * row^q over the pixels equal to the target label, tracking column and row
// itself from the configured image width. The moment and a sticky overflow flag are
// delivered as one output word on the pixel marked last, after which the sum and position
// are cleared. One pixel is worked on at a time: a pixel word goes through the load, the
// two factor steps and the add before the next is taken. A matching pixel is multiplied
// by its column p times and its row q times, p and q being the configured orders clamped
// to MAX_ORDER; any other pixel skips the products. A single shared multiplier applies
// one power factor per cycle. A last pixel waits in its final step while the previous
// result word is still untaken; otherwise the output register lets new pixels in meanwhile.
// Configuration writes are taken at any time and must only be made while the block is idle.
module region_raw_moment #(
    parameter int MAX_DIM   = 1024,
    parameter int MAX_ORDER = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rrm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rrm_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rrm_pkg::t_out_word             o_out_word
);
    import rrm_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    cfg_we;

    // Configuration writes are always accepted.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    rrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rrm_dpath #(
        .MAX_DIM   (MAX_DIM),
        .MAX_ORDER (MAX_ORDER)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Once a pixel word is taken, no further word is taken in the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("pixel word accepted while another is in progress");

    // A new result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(o_out_valid && !i_out_ready))
        else $error("result word overwritten before it was taken");

    // An overflowing sum is reported saturated.
    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.overflow) |-> (o_out_word.moment_sum == SUM_MAX))
        else $error("overflow flagged without a saturated sum");

    // Only one datapath operation is commanded at a time.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mul_x, cmd.mul_y, cmd.add}))
        else $error("conflicting datapath commands");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the raw region moment block (region_raw_moment).
// It depends on rrm_pkg and the block's RTL; it predicts each moment word itself and
// checks every output word against that prediction.
`timescale 1ns / 1ps

module tb_top;
    import rrm_pkg::*;

    localparam int DIM_LIMIT     = 1024;
    localparam int ORDER_LIMIT   = 3;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 200;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_word;

    // Mirror of the configuration registers, updated as writes are taken.
    logic [7:0]  label_reg = 8'd0;
    logic [1:0]  ox_reg    = 2'd0;
    logic [1:0]  oy_reg    = 2'd0;
    logic [10:0] width_reg = WIDTH_RESET;

    // Predicted position and running sum of the image in flight.
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    logic [30:0] moment_acc = '0;
    logic        ovf_seen   = 1'b0;

    t_out_word pending_moments[$];
    t_out_word predicted_word;
    t_out_word oldest_word;
    int        mismatch_count = 0;
    int        lasts_sent     = 0;
    int        words_taken    = 0;
    int        burst_left     = 0;
    int        quiet_cycles   = 0;
    int        ready_left     = 0;
    int        ready_kind     = 0;
    logic [7:0] cur_target    = 8'd0;

    region_raw_moment #(
        .MAX_DIM   (DIM_LIMIT),
        .MAX_ORDER (ORDER_LIMIT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // Integer power, capped once it passes the term cap.
    function automatic logic [63:0] capped_power(int unsigned base, logic [1:0] ex);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < ex; k++) begin
            p = p * base;
            if (p > TERM_CAP) p = TERM_CAP;
        end
        return p;
    endfunction

    // Advances the predicted moment by one pixel; returns 1 when a word is due.
    function automatic bit moment_step(t_in_word w, output t_out_word res);
        int unsigned eff_w;
        logic [63:0] term;
        res = '0;
        if (width_reg == 0) eff_w = 1;
        else if (width_reg > DIM_LIMIT) eff_w = DIM_LIMIT;
        else eff_w = width_reg;
        if (w.pixel == label_reg) begin
            term = capped_power(col_pos, ox_reg) * capped_power(row_pos, oy_reg);
            if (term > TERM_CAP) term = TERM_CAP;
            term = term + moment_acc;
            if (term > SUM_MAX) begin
                moment_acc = SUM_MAX;
                ovf_seen   = 1'b1;
            end else begin
                moment_acc = term[30:0];
            end
        end
        if (w.last_pixel) begin
            res.moment_sum = moment_acc;
            res.overflow   = ovf_seen;
            moment_acc = '0;
            ovf_seen   = 1'b0;
            col_pos    = 0;
            row_pos    = 0;
            return 1'b1;
        end
        if (col_pos + 1 >= eff_w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= DIM_LIMIT) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Watches all three channels: mirrors register writes, predicts on each pixel
    // word taken and checks each moment word taken against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                words_taken <= words_taken + 1;
                if (pending_moments.size() == 0) begin
                    flag_mismatch("unexpected word, moment_sum", o_out_word.moment_sum, -1);
                end else begin
                    oldest_word = pending_moments.pop_front();
                    if (o_out_word.moment_sum !== oldest_word.moment_sum)
                        flag_mismatch("moment_sum", o_out_word.moment_sum,
                                      oldest_word.moment_sum);
                    if (o_out_word.overflow !== oldest_word.overflow)
                        flag_mismatch("overflow", o_out_word.overflow, oldest_word.overflow);
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (moment_step(i_in_word, predicted_word))
                    pending_moments.push_back(predicted_word);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET_LABEL: label_reg = i_cfg_data[7:0];
                    CFG_ORDER_X:      ox_reg    = i_cfg_data[1:0];
                    CFG_ORDER_Y:      oy_reg    = i_cfg_data[1:0];
                    CFG_IMAGE_WIDTH:  width_reg = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // The receiver alternates between ready stretches, full stalls and random stalls.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_kind <= $urandom_range(0, 3);
            ready_left <= $urandom_range(1, 30);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_kind)
            2:       i_out_ready <= 1'b0;
            3:       i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= 1'b1;
        endcase
    end

    // Ends the run when no word has moved on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one pixel word; the sender works in bursts with random gaps between them.
    task automatic send_pixel(logic [7:0] pix, logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid            <= 1'b1;
        i_in_word.pixel      <= pix;
        i_in_word.last_pixel <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        if (last) lasts_sent++;
    endtask

    // Stops sending, waits for every moment word due and lets the block drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (words_taken < lasts_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; the valid is kept high when another write follows.
    task automatic cfg_write(logic [1:0] idx, logic [10:0] data, logic more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    // Writes all four registers once the block is idle; unused high bits carry junk.
    task automatic set_config(logic [7:0] lbl, logic [1:0] ox, logic [1:0] oy,
                              logic [10:0] width);
        logic [31:0] junk;
        junk = $urandom;
        settle();
        cfg_write(CFG_TARGET_LABEL, {junk[2:0], lbl}, 1'b1);
        cfg_write(CFG_ORDER_X, {junk[11:3], ox}, 1'b1);
        cfg_write(CFG_ORDER_Y, {junk[20:12], oy}, 1'b1);
        cfg_write(CFG_IMAGE_WIDTH, width, 1'b0);
        cur_target = lbl;
    endtask

    // Sends a raster of one fill label with up to two marked pixels; the final one is last.
    task automatic send_raster(int count, logic [7:0] fill, int mark_a, int mark_b,
                               logic [7:0] mark_label);
        for (int i = 0; i < count; i++)
            send_pixel((i == mark_a || i == mark_b) ? mark_label : fill, i == count - 1);
    endtask

    function automatic logic [10:0] pick_width();
        case ($urandom_range(0, 7))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd1024;
            3:       return 11'd2047;
            4:       return 11'($urandom_range(0, 2047));
            default: return 11'($urandom_range(2, 8));
        endcase
    endfunction

    // Reset values: label 0, orders 0 and full width, so the word is a pixel count.
    task automatic test_reset_state();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
    endtask

    // The top label value, mixed with the bottom one, on a two-column image.
    task automatic test_label_extremes();
        set_config(8'd255, 2'd1, 2'd1, 11'd2);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
    endtask

    // A spread of order pairs, the highest on both axes among them.
    task automatic test_orders();
        logic [1:0] xs [4];
        logic [1:0] ys [4];
        xs = '{2'd1, 2'd3, 2'd2, 2'd0};
        ys = '{2'd2, 2'd3, 2'd0, 2'd1};
        for (int c = 0; c < 4; c++) begin
            set_config(8'd17, xs[c], ys[c], 11'd3);
            send_raster(5, 8'd17, -1, -1, 8'd17);
        end
    endtask

    // A width of zero behaves as one; a width above the limit behaves as the limit.
    task automatic test_width_limits();
        set_config(8'd4, 2'd0, 2'd1, 11'd0);
        send_raster(4, 8'd4, -1, -1, 8'd4);
        set_config(8'd4, 2'd1, 2'd0, 11'd2047);
        send_raster(5, 8'd4, -1, -1, 8'd4);
    endtask

    // The width drops below the current column part way through an image, which
    // must start a new row; no word may appear before the last pixel.
    task automatic test_width_lowered();
        set_config(8'd9, 2'd1, 2'd1, 11'd8);
        for (int i = 0; i < 6; i++) send_pixel(8'd9, 1'b0);
        settle();
        cfg_write(CFG_IMAGE_WIDTH, 11'd3, 1'b0);
        send_raster(4, 8'd9, -1, -1, 8'd9);
    endtask

    // Saturation by two large terms together, then by a single term above the
    // largest sum; a small image afterwards shows the flag cleared. A width of one
    // runs the row up quickly, and a wider row then reaches a large column.
    task automatic test_saturation();
        set_config(8'd9, 2'd3, 2'd3, 11'd1);
        for (int i = 0; i < 34; i++) send_pixel(8'd0, 1'b0);
        settle();
        cfg_write(CFG_IMAGE_WIDTH, 11'd40, 1'b0);
        send_raster(33, 8'd0, 31, 32, 8'd9);
        settle();
        cfg_write(CFG_IMAGE_WIDTH, 11'd1, 1'b0);
        for (int i = 0; i < 37; i++) send_pixel(8'd0, 1'b0);
        settle();
        cfg_write(CFG_IMAGE_WIDTH, 11'd64, 1'b0);
        send_raster(37, 8'd0, 35, -1, 8'd9);
        send_raster(3, 8'd9, -1, -1, 8'd9);
    endtask

    // Random images under random settings, some with the width changed mid-image.
    task automatic test_random_images();
        int sent;
        int len;
        int split;
        logic [7:0] lbl;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       lbl = 8'd0;
                    1:       lbl = 8'd255;
                    default: lbl = 8'($urandom_range(0, 255));
                endcase
                set_config(lbl, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           pick_width());
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
            split = (len > 3 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 2) : -1;
            for (int i = 0; i < len; i++) begin
                if (i == split) begin
                    settle();
                    cfg_write(CFG_IMAGE_WIDTH, pick_width(), 1'b0);
                end
                send_pixel($urandom_range(0, 1) ? cur_target : 8'($urandom_range(0, 255)),
                           i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_label_extremes();
        test_orders();
        test_width_limits();
        test_width_lowered();
        test_saturation();
        test_random_images();
        settle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
